### hdl/tcp_window_scale_tagger_top_macros.svh
// Assertion macros used by the tagger datapath (tcpws_dp).
// Depends on clk and rst_n being in scope where the macros are used.
`ifndef TCP_WINDOW_SCALE_TAGGER_TOP_MACROS_SVH
`define TCP_WINDOW_SCALE_TAGGER_TOP_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define TWST_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define TWST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/tcpws_pkg.sv
// Package for the TCP window-scale tagger: payload structs, controller
// commands and status, state and register codes. No dependencies.
package tcpws_pkg;

    localparam int          CFG_IDX_W     = 1;
    localparam logic [3:0]  MAX_SHIFT     = 4'd14;
    localparam logic [15:0] PORT_A_RESET  = 16'd5001;
    localparam logic [15:0] PORT_B_RESET  = 16'd80;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PORT_A = 1'b0,
        REG_PORT_B = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic        is_tcp;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] sport;
        logic [15:0] dport;
        logic        syn_flag;
        logic        ack_flag;
        logic        wscale_present;
        logic [3:0]  wscale_shift;
    } pkt_t;

    typedef struct packed {
        logic       rewrite;
        logic [3:0] reserved_value;
        logic       stored;
        logic       table_full;
    } res_t;

    typedef struct packed {
        logic load;
        logic clear_step;
        logic scan_step;
        logic update;
        logic tbl_read;
        logic tbl_capture;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic tracked;
        logic syn;
        logic ack;
        logic scan_done;
        logic both_hit;
        logic out_free;
    } sts_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_UPDATE,
        ST_TRD,
        ST_TCAP,
        ST_EMIT
    } state_t;

endpackage

### hdl/tcpws_ctrl.sv
// Controller of the tagger: sequences table clear, list scan, update or
// lookup, and result hand-off. Depends on tcpws_pkg.
module tcpws_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output tcpws_pkg::cmd_t cmd,
    input  tcpws_pkg::sts_t sts
);
    import tcpws_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (sts.tracked && (sts.syn || sts.ack))
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done)
                begin
                    priority if (sts.syn)
                    begin
                        state_next = ST_UPDATE;
                    end
                    else if (sts.both_hit)
                    begin
                        state_next = ST_TRD;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_EMIT;
            end
            ST_TRD:
            begin
                cmd.tbl_read = 1'b1;
                state_next   = ST_TCAP;
            end
            ST_TCAP:
            begin
                cmd.tbl_capture = 1'b1;
                state_next      = ST_EMIT;
            end
            ST_EMIT:
            begin
                // hold the result until the output slot frees up
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

### hdl/tcpws_dp.sv
// Datapath of the tagger: config registers, address lists, scale table,
// scan pipeline and output register. Depends on tcpws_pkg and the macro header.
`include "tcp_window_scale_tagger_top_macros.svh"

module tcpws_dp
#(
    parameter int SRC_ENTRIES = 64,
    parameter int DST_ENTRIES = 64
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  tcpws_pkg::pkt_t                     in_data,
    output tcpws_pkg::res_t                     out_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    input  logic                                cfg_valid,
    input  logic [tcpws_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [15:0]                         cfg_data,
    input  tcpws_pkg::cmd_t                     cmd,
    output tcpws_pkg::sts_t                     sts
);
    import tcpws_pkg::*;

    localparam int SIW    = $clog2(SRC_ENTRIES);
    localparam int DIW    = $clog2(DST_ENTRIES);
    localparam int SCW    = $clog2(SRC_ENTRIES + 1);
    localparam int DCW    = $clog2(DST_ENTRIES + 1);
    localparam int MAXN   = (SRC_ENTRIES > DST_ENTRIES) ? SRC_ENTRIES : DST_ENTRIES;
    localparam int PW     = $clog2(MAXN + 1);
    localparam int TW     = SIW + DIW;
    localparam int TDEPTH = 1 << TW;

    logic [31:0] src_mem [SRC_ENTRIES];
    logic [31:0] dst_mem [DST_ENTRIES];
    logic [3:0]  tbl_mem [TDEPTH];

    pkt_t        item_reg;
    logic [15:0] port_a_reg;
    logic [15:0] port_b_reg;
    logic [SCW-1:0] scnt_reg;
    logic [DCW-1:0] dcnt_reg;
    logic [PW-1:0]  ptr_reg;
    logic        src_pend_reg;
    logic        dst_pend_reg;
    logic [31:0] src_q_reg;
    logic [31:0] dst_q_reg;
    logic [SIW-1:0] src_qi_reg;
    logic [DIW-1:0] dst_qi_reg;
    logic        s_hit_reg;
    logic        d_hit_reg;
    logic [SIW-1:0] s_idx_reg;
    logic [DIW-1:0] d_idx_reg;
    logic [TW-1:0]  clr_ptr_reg;
    logic [3:0]  tbl_q_reg;
    res_t        res_reg;
    res_t        out_reg;
    logic        out_valid_reg;

    logic        tracked;
    logic        src_rd_en;
    logic        dst_rd_en;
    logic        scan_end;
    logic        src_match;
    logic        dst_match;
    logic        s_full;
    logic        d_full;
    logic        s_new;
    logic        d_new;
    logic [SIW-1:0] s_ix;
    logic [DIW-1:0] d_ix;
    logic        store_ok;
    logic [3:0]  sat_shift;
    logic        tbl_wr_en;
    logic [TW-1:0]  tbl_wr_addr;
    logic [3:0]  tbl_wr_data;
    logic        out_free;

    always_comb
    begin
        tracked = item_reg.is_tcp &&
                  (item_reg.sport == port_a_reg || item_reg.dport == port_a_reg ||
                   item_reg.sport == port_b_reg || item_reg.dport == port_b_reg);

        scan_end  = (ptr_reg >= PW'(scnt_reg)) && (ptr_reg >= PW'(dcnt_reg));
        src_rd_en = cmd.scan_step && (ptr_reg < PW'(scnt_reg));
        dst_rd_en = cmd.scan_step && (ptr_reg < PW'(dcnt_reg));
        src_match = src_pend_reg && !s_hit_reg && (src_q_reg == item_reg.src_ip);
        dst_match = dst_pend_reg && !d_hit_reg && (dst_q_reg == item_reg.dst_ip);

        s_full   = !s_hit_reg && (scnt_reg == SCW'(SRC_ENTRIES));
        d_full   = !d_hit_reg && (dcnt_reg == DCW'(DST_ENTRIES));
        s_new    = !s_hit_reg && !s_full;
        d_new    = !d_hit_reg && !d_full;
        s_ix     = s_hit_reg ? s_idx_reg : scnt_reg[SIW-1:0];
        d_ix     = d_hit_reg ? d_idx_reg : dcnt_reg[DIW-1:0];
        store_ok = !s_full && !d_full;

        if (!item_reg.wscale_present)
        begin
            sat_shift = 4'd0;
        end
        else if (item_reg.wscale_shift > MAX_SHIFT)
        begin
            sat_shift = MAX_SHIFT;
        end
        else
        begin
            sat_shift = item_reg.wscale_shift;
        end

        tbl_wr_en   = cmd.clear_step || (cmd.update && store_ok);
        tbl_wr_addr = cmd.clear_step ? clr_ptr_reg : {s_ix, d_ix};
        tbl_wr_data = cmd.clear_step ? 4'd0 : sat_shift;

        out_free = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        sts.clear_done = &clr_ptr_reg;
        sts.tracked    = tracked;
        sts.syn        = item_reg.syn_flag;
        sts.ack        = item_reg.ack_flag;
        sts.scan_done  = scan_end && !src_pend_reg && !dst_pend_reg;
        sts.both_hit   = s_hit_reg && d_hit_reg;
        sts.out_free   = out_free;
    end

    assign out_data  = out_reg;
    assign out_valid = out_valid_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            port_a_reg    <= PORT_A_RESET;
            port_b_reg    <= PORT_B_RESET;
            scnt_reg      <= '0;
            dcnt_reg      <= '0;
            ptr_reg       <= '0;
            src_pend_reg  <= 1'b0;
            dst_pend_reg  <= 1'b0;
            s_hit_reg     <= 1'b0;
            d_hit_reg     <= 1'b0;
            clr_ptr_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_PORT_A: port_a_reg <= cfg_data;
                    REG_PORT_B: port_b_reg <= cfg_data;
                endcase
            end

            if (cmd.clear_step)
            begin
                clr_ptr_reg <= clr_ptr_reg + 1'b1;
            end

            if (cmd.load)
            begin
                ptr_reg      <= '0;
                src_pend_reg <= 1'b0;
                dst_pend_reg <= 1'b0;
                s_hit_reg    <= 1'b0;
                d_hit_reg    <= 1'b0;
            end
            else
            begin
                src_pend_reg <= src_rd_en;
                dst_pend_reg <= dst_rd_en;
                if (cmd.scan_step && !scan_end)
                begin
                    ptr_reg <= ptr_reg + 1'b1;
                end
                if (src_match)
                begin
                    s_hit_reg <= 1'b1;
                end
                if (dst_match)
                begin
                    d_hit_reg <= 1'b1;
                end
            end

            // append new addresses on a SYN
            if (cmd.update && s_new)
            begin
                scnt_reg <= scnt_reg + 1'b1;
            end
            if (cmd.update && d_new)
            begin
                dcnt_reg <= dcnt_reg + 1'b1;
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_data;
            res_reg  <= '0;
        end
        if (src_match)
        begin
            s_idx_reg <= src_qi_reg;
        end
        if (dst_match)
        begin
            d_idx_reg <= dst_qi_reg;
        end
        if (cmd.update)
        begin
            res_reg.stored     <= store_ok;
            res_reg.table_full <= s_full || d_full;
        end
        if (cmd.tbl_capture)
        begin
            res_reg.rewrite        <= (tbl_q_reg != 4'd0);
            res_reg.reserved_value <= tbl_q_reg;
        end
        if (cmd.emit)
        begin
            out_reg <= res_reg;
        end
    end

    // address lists
    always_ff @(posedge clk)
    begin
        if (cmd.update && s_new)
        begin
            src_mem[scnt_reg[SIW-1:0]] <= item_reg.src_ip;
        end
        if (src_rd_en)
        begin
            src_q_reg  <= src_mem[ptr_reg[SIW-1:0]];
            src_qi_reg <= ptr_reg[SIW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update && d_new)
        begin
            dst_mem[dcnt_reg[DIW-1:0]] <= item_reg.dst_ip;
        end
        if (dst_rd_en)
        begin
            dst_q_reg  <= dst_mem[ptr_reg[DIW-1:0]];
            dst_qi_reg <= ptr_reg[DIW-1:0];
        end
    end

    // scale table
    always_ff @(posedge clk)
    begin
        if (tbl_wr_en)
        begin
            tbl_mem[tbl_wr_addr] <= tbl_wr_data;
        end
        if (cmd.tbl_read)
        begin
            tbl_q_reg <= tbl_mem[{s_idx_reg, d_idx_reg}];
        end
    end

    `TWST_ASSERT_NOW(a_scnt_bound, 1'b1, scnt_reg <= SCW'(SRC_ENTRIES), "source count overrun")
    `TWST_ASSERT_NOW(a_emit_free, cmd.emit, !out_valid_reg || out_ready, "result overwritten")
    `TWST_ASSERT_NOW(a_rewrite_val, out_valid_reg && out_reg.rewrite, out_reg.reserved_value != 4'd0, "rewrite with zero shift")
    `TWST_ASSERT_NEXT(a_store_full, cmd.update && store_ok, res_reg.stored && !res_reg.table_full, "store and full both set")

endmodule

### hdl/tcp_window_scale_tagger_top.sv
// Channel  | Dir | Handshake                | Payload
// in       | in  | in_valid / in_ready      | in_data   (tcpws_pkg::pkt_t)
// out      | out | out_valid / out_ready    | out_data  (tcpws_pkg::res_t)
// cfg      | in  | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// One packet at a time. Untracked packets, or ones without SYN or ACK, go from the
// check straight to the result. A tracked SYN scans both address lists, then updates
// the lists and the scale table; an ACK with a known pair scans, reads the table and
// captures the tag; other ACKs end after the scan. The serial list scan reads one
// entry of each list per cycle through the list memory read port.
// After reset the scale table is cleared one entry a cycle, across
// all 2**(clog2(SRC_ENTRIES) + clog2(DST_ENTRIES)) entries (4096 by default), while
// in_ready stays low. The next packet is taken while a result waits in the output
// register; a stalled output holds the block only when the next result is ready.
// Depends on tcpws_pkg, tcpws_ctrl and tcpws_dp.
module tcp_window_scale_tagger_top
#(
    parameter int SRC_ENTRIES = 64,
    parameter int DST_ENTRIES = 64
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  tcpws_pkg::pkt_t                 in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output tcpws_pkg::res_t                 out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tcpws_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                     cfg_data
);
    import tcpws_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // registers take a write in any cycle
    assign cfg_ready = 1'b1;

    tcpws_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    tcpws_dp
    #(
        .SRC_ENTRIES (SRC_ENTRIES),
        .DST_ENTRIES (DST_ENTRIES)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

### tb/tb_tcp_window_scale_tagger_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for tcp_window_scale_tagger_top: sends packet summaries and
// port writes, predicts each tag from a local copy of the address lists and scale table.
// Depends on tcpws_pkg and the tagger RTL.
module tb_tcp_window_scale_tagger_top;
    import tcpws_pkg::*;

    localparam int SRC_ENTRIES = 64;
    localparam int DST_ENTRIES = 64;
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_LEN    = 400;
    localparam int DRAIN_WAIT  = 100;
    localparam int POOL_SIZE   = 20;
    localparam int PHASE_ITEMS = 150;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    pkt_t                 in_data   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    res_t                 out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0]          cfg_data  = '0;

    // local copy of the block's state
    logic [15:0] watch_a = PORT_A_RESET;
    logic [15:0] watch_b = PORT_B_RESET;
    logic [31:0] seen_src [SRC_ENTRIES];
    logic [31:0] seen_dst [DST_ENTRIES];
    int          src_used = 0;
    int          dst_used = 0;
    logic [3:0]  scale_tbl [SRC_ENTRIES][DST_ENTRIES];
    res_t        expected_tags [$];

    logic [31:0] src_pool [POOL_SIZE];
    logic [31:0] dst_pool [POOL_SIZE];

    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic hold_req       = 1'b0;
    int   mismatches     = 0;
    int   quiet_cycles   = 0;

    tcp_window_scale_tagger_top
    #(
        .SRC_ENTRIES (SRC_ENTRIES),
        .DST_ENTRIES (DST_ENTRIES)
    )
    u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int slot_of(input bit dst_side, input logic [31:0] addr);
        int used;
        used = dst_side ? dst_used : src_used;
        for (int k = 0; k < used; k++)
        begin
            if ((dst_side ? seen_dst[k] : seen_src[k]) == addr)
                return k;
        end
        return -1;
    endfunction

    // find the address or append it; a full list leaves the slot at -1
    function automatic int claim_slot(input bit dst_side, input logic [31:0] addr,
                                      inout logic full);
        int k;
        k = slot_of(dst_side, addr);
        if (k < 0)
        begin
            if ((dst_side ? dst_used : src_used) >= (dst_side ? DST_ENTRIES : SRC_ENTRIES))
                full = 1'b1;
            else if (dst_side)
            begin
                seen_dst[dst_used] = addr;
                k = dst_used;
                dst_used++;
            end
            else
            begin
                seen_src[src_used] = addr;
                k = src_used;
                src_used++;
            end
        end
        return k;
    endfunction

    function automatic res_t tag_for_packet(input pkt_t p);
        res_t r;
        logic tracked;
        logic full;
        int   si;
        int   di;
        r = '0;
        full = 1'b0;
        tracked = p.is_tcp && (p.sport == watch_a || p.dport == watch_a ||
                               p.sport == watch_b || p.dport == watch_b);
        if (tracked && p.syn_flag)
        begin
            si = claim_slot(1'b0, p.src_ip, full);
            di = claim_slot(1'b1, p.dst_ip, full);
            r.table_full = full;
            if (si >= 0 && di >= 0)
            begin
                scale_tbl[si][di] = !p.wscale_present ? 4'd0 :
                                    (p.wscale_shift > MAX_SHIFT) ? MAX_SHIFT : p.wscale_shift;
                r.stored = 1'b1;
            end
        end
        else if (tracked && p.ack_flag)
        begin
            si = slot_of(1'b0, p.src_ip);
            di = slot_of(1'b1, p.dst_ip);
            if (si >= 0 && di >= 0 && scale_tbl[si][di] != 4'd0)
            begin
                r.rewrite = 1'b1;
                r.reserved_value = scale_tbl[si][di];
            end
        end
        return r;
    endfunction

    function automatic pkt_t mk_pkt(input bit tcp, input logic [31:0] sip,
                                    input logic [31:0] dip, input logic [15:0] sp,
                                    input logic [15:0] dp, input bit syn, input bit ack,
                                    input bit wsp, input logic [3:0] ws);
        pkt_t p;
        p.is_tcp         = tcp;
        p.src_ip         = sip;
        p.dst_ip         = dip;
        p.sport          = sp;
        p.dport          = dp;
        p.syn_flag       = syn;
        p.ack_flag       = ack;
        p.wscale_present = wsp;
        p.wscale_shift   = ws;
        return p;
    endfunction

    // mostly tracked handshakes over a small address pool, the rest raw noise
    function automatic pkt_t random_pkt();
        pkt_t        p;
        logic [15:0] hit;
        int          kind;
        p = mk_pkt(1'($urandom_range(1)), $urandom, $urandom, 16'($urandom_range(65535)),
                   16'($urandom_range(65535)), 1'($urandom_range(1)),
                   1'($urandom_range(1)), 1'($urandom_range(1)),
                   4'($urandom_range(15)));
        if ($urandom_range(99) >= 15)
        begin
            p.is_tcp = 1'b1;
            p.src_ip = src_pool[$urandom_range(POOL_SIZE - 1)];
            p.dst_ip = dst_pool[$urandom_range(POOL_SIZE - 1)];
            hit = $urandom_range(1) ? watch_a : watch_b;
            if ($urandom_range(1))
                p.sport = hit;
            else
                p.dport = hit;
            kind = $urandom_range(99);
            p.syn_flag = (kind < 35);
            p.ack_flag = (kind < 35) ? 1'($urandom_range(1)) : (kind < 90);
            p.wscale_present = ($urandom_range(99) < 80);
        end
        return p;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // hold valid high between back-to-back requests; drop it only for idle cycles
    task automatic send_pkt(input pkt_t p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= p;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_tags.push_back(tag_for_packet(p));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_tags.size() != 0);
    endtask

    task automatic set_ports(input logic [15:0] a, input logic [15:0] b);
        wait_idle();
        for (int k = 0; k < 2; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= (k == 0) ? REG_PORT_A : REG_PORT_B;
            cfg_data  <= (k == 0) ? a : b;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
        watch_a = a;
        watch_b = b;
    endtask

    task automatic set_idling(input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
    endtask

    task automatic test_directed();
        logic [31:0] lo;
        logic [31:0] hi;
        lo = 32'h0000_0000;
        hi = 32'hFFFF_FFFF;
        set_idling(0, 0);
        send_pkt(mk_pkt(0, lo, hi, 80, 80, 1, 0, 1, 7));        // not TCP
        send_pkt(mk_pkt(1, lo, hi, 1234, 4321, 1, 0, 1, 7));    // no watched port
        send_pkt(mk_pkt(1, lo, lo, 80, 0, 0, 1, 0, 0));         // ACK before any SYN
        send_pkt(mk_pkt(1, lo, hi, 1234, 80, 1, 0, 1, 7));
        send_pkt(mk_pkt(1, lo, hi, 80, 65535, 0, 1, 0, 0));
        send_pkt(mk_pkt(1, lo, hi, 5001, 0, 1, 1, 1, 15));      // SYN+ACK, shift saturates
        send_pkt(mk_pkt(1, lo, hi, 0, 5001, 0, 1, 1, 3));
        send_pkt(mk_pkt(1, hi, lo, 65535, 80, 1, 0, 1, 14));
        send_pkt(mk_pkt(1, hi, lo, 80, 5001, 0, 1, 0, 0));
        send_pkt(mk_pkt(1, lo, hi, 80, 80, 1, 0, 0, 9));        // SYN without scale option
        send_pkt(mk_pkt(1, lo, hi, 80, 80, 0, 1, 0, 0));
        send_pkt(mk_pkt(1, hi, lo, 5001, 5001, 0, 0, 1, 5));    // neither SYN nor ACK
        send_pkt(mk_pkt(1, hi, 32'h1234_5678, 80, 1, 0, 1, 0, 0));
        send_pkt(mk_pkt(1, hi, hi, 80, 1, 1, 0, 1, 0));
        send_pkt(mk_pkt(1, hi, hi, 1, 80, 0, 1, 0, 0));
        send_pkt(mk_pkt(1, hi, hi, 80, 1, 1, 0, 1, 1));
        send_pkt(mk_pkt(1, hi, hi, 2, 80, 0, 1, 1, 15));
        send_pkt(mk_pkt(0, hi, hi, 80, 80, 0, 1, 1, 15));
        send_pkt(mk_pkt(1, hi, hi, 65535, 65535, 0, 1, 1, 15));
    endtask

    task automatic test_port_extremes();
        logic [31:0] lo;
        logic [31:0] hi;
        lo = 32'h0000_0000;
        hi = 32'hFFFF_FFFF;
        set_ports(16'd0, 16'hFFFF);
        send_pkt(mk_pkt(1, hi, lo, 0, 1234, 0, 1, 0, 0));
        send_pkt(mk_pkt(1, hi, lo, 1234, 65535, 0, 1, 0, 0));
        send_pkt(mk_pkt(1, hi, lo, 80, 5001, 0, 1, 0, 0));      // old ports no longer watched
        send_pkt(mk_pkt(1, hi, hi, 65535, 0, 1, 0, 1, 12));
        set_ports(16'hFFFF, 16'd0);
        send_pkt(mk_pkt(1, hi, hi, 0, 0, 0, 1, 0, 0));
        send_pkt(mk_pkt(1, hi, hi, 7, 65535, 0, 1, 1, 4));
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input logic [15:0] a, input logic [15:0] b);
        set_ports(a, b);
        set_idling(idle_pct, stall_pct);
        repeat (PHASE_ITEMS)
            send_pkt(random_pkt());
    endtask

    // starve the output so the block fills and drops in_ready
    task automatic test_backpressure();
        set_idling(0, 0);
        hold_req = 1'b1;
        repeat (12)
            send_pkt(random_pkt());
        hold_req = 1'b0;
    endtask

    task automatic test_list_overflow();
        set_idling(17, 17);
        repeat (70)
            send_pkt(mk_pkt(1, $urandom, dst_pool[$urandom_range(POOL_SIZE - 1)],
                            16'($urandom_range(65535)), watch_a, 1,
                            1'($urandom_range(1)), 1, 4'($urandom_range(15))));
        repeat (70)
            send_pkt(mk_pkt(1, src_pool[$urandom_range(POOL_SIZE - 1)], $urandom,
                            watch_b, 16'($urandom_range(65535)), 1,
                            1'($urandom_range(1)), 1'($urandom_range(1)),
                            4'($urandom_range(15))));
        repeat (60)
            send_pkt(random_pkt());
    endtask

    initial
    begin : receiver
        int   hold_left;
        logic armed;
        hold_left = 0;
        armed = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !armed)
            begin
                armed = 1'b1;
                hold_left = HOLD_LEN;
            end
            else if (!hold_req)
            begin
                armed = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_tags.size() == 0)
                begin
                    $display("%0t: result with nothing expected, got %h", $time, out_data);
                    mismatches++;
                end
                else
                begin
                    want = expected_tags.pop_front();
                    check_field("rewrite", int'(want.rewrite), int'(out_data.rewrite));
                    check_field("reserved_value", int'(want.reserved_value),
                                int'(out_data.reserved_value));
                    check_field("stored", int'(want.stored), int'(out_data.stored));
                    check_field("table_full", int'(want.table_full),
                                int'(out_data.table_full));
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        foreach (scale_tbl[i, j])
            scale_tbl[i][j] = 4'd0;
        src_pool[0] = 32'h0000_0000;
        src_pool[1] = 32'hFFFF_FFFF;
        dst_pool[0] = 32'h0000_0000;
        dst_pool[1] = 32'hFFFF_FFFF;
        for (int k = 2; k < POOL_SIZE; k++)
        begin
            src_pool[k] = $urandom;
            dst_pool[k] = $urandom;
        end
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_port_extremes();
        test_random_traffic(0, 0, 16'($urandom_range(65535)), 16'($urandom_range(65535)));
        test_random_traffic(58, 0, 16'd443, 16'd443);
        test_random_traffic(0, 58, PORT_A_RESET, PORT_B_RESET);
        test_random_traffic(17, 17, 16'($urandom_range(65535)), PORT_B_RESET);
        test_backpressure();
        test_list_overflow();

        wait_idle();
        repeat (DRAIN_WAIT)
            @(posedge clk);
        if (mismatches == 0 && expected_tags.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### tcp_window_scale_tagger_top.f
+incdir+hdl
hdl/tcpws_pkg.sv
hdl/tcpws_ctrl.sv
hdl/tcpws_dp.sv
hdl/tcp_window_scale_tagger_top.sv
tb/tb_tcp_window_scale_tagger_top.sv
